/* hdl/m7fs_pkg.sv */
package m7fs_pkg;

   // Map geometry and screen constants
   localparam int MapWidthTiles  = 64;
   localparam int MapHeightTiles = 64;
   localparam int ScreenWidth    = 128;

   // Request opcodes
   localparam logic [1:0] OP_MAP_WRITE  = 2'd0;
   localparam logic [1:0] OP_TILE_WRITE = 2'd1;
   localparam logic [1:0] OP_RENDER     = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_HEIGHT_PRODUCT = 3'd0;
   localparam logic [2:0] REG_HSCALE_DIV     = 3'd1;
   localparam logic [2:0] REG_HORIZON        = 3'd2;
   localparam logic [2:0] REG_RENDER_SELECT  = 3'd3;
   localparam logic [2:0] REG_COS            = 3'd4;
   localparam logic [2:0] REG_SIN            = 3'd5;
   localparam logic [2:0] REG_CAM_X          = 3'd6;
   localparam logic [2:0] REG_CAM_Y          = 3'd7;

   // Render select codes
   localparam logic [1:0] SEL_FLOOR   = 2'd1;
   localparam logic [1:0] SEL_CEILING = 2'd2;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] addr;
      logic [7:0]  data;
      logic [6:0]  col;
      logic [5:0]  row;
   } item_type;

   typedef struct packed {
      item_type item;
      logic     zero_div;
      logic     neg;
   } div1_side_type;

   typedef struct packed {
      item_type           item;
      logic               skip;
      logic signed [31:0] line_dist;
   } s2_type;

   typedef struct packed {
      item_type           item;
      logic               skip;
      logic signed [31:0] line_dist;
      logic signed [31:0] dcos;
      logic signed [31:0] dsin;
   } s3_type;

   typedef struct packed {
      item_type           item;
      logic               skip;
      logic               neg;
      logic               den_zero;
      logic               num_neg;
      logic signed [31:0] dcos;
      logic signed [31:0] dsin;
   } div2_side_type;

   typedef struct packed {
      item_type           item;
      logic               skip;
      logic signed [31:0] hs;
      logic signed [31:0] dcos;
      logic signed [31:0] dsin;
   } s4_type;

   typedef struct packed {
      item_type           item;
      logic               skip;
      logic signed [31:0] ldx;
      logic signed [31:0] ldy;
      logic [31:0]        basex;
      logic [31:0]        basey;
   } s5_type;

   typedef struct packed {
      item_type    item;
      logic        skip;
      logic [31:0] px;
      logic [31:0] py;
   } s6_type;

   typedef struct packed {
      item_type   item;
      logic       skip;
      logic       outside;
      logic [2:0] sx3;
      logic [2:0] sy3;
   } s7_type;

   typedef struct packed {
      item_type   item;
      logic       skip;
      logic       outside;
      logic [2:0] sx3;
   } s8_type;

endpackage

/* hdl/m7fs_ram.sv */
module m7fs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, register read data
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/m7fs_udiv.sv */
module m7fs_udiv #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_vld,
   output logic [NUM_W-1:0]  quot,
   output logic [SIDE_W-1:0] side_out
);

   // One quotient bit per stage, most significant first
   logic              vld_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [NUM_W-1:0]  q_ff    [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              vld_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [NUM_W-1:0]  num_prev;
      logic [NUM_W-1:0]  q_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rem_prev  = '0;
         assign num_prev  = num;
         assign q_prev    = '0;
         assign den_prev  = den;
         assign side_prev = side_in;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign num_prev  = num_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // Shift in the next numerator bit and try the subtract
      always_comb begin
         trial  = {rem_prev, num_prev[NUM_W-1]};
         ge     = (trial >= {1'b0, den_prev});
         rem_in = ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            num_ff[k]  <= num_prev << 1;
            q_ff[k]    <= {q_prev[NUM_W-2:0], ge};
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_vld  = vld_ff[NUM_W-1];
   assign quot     = q_ff[NUM_W-1];
   assign side_out = side_ff[NUM_W-1];

endmodule

/* hdl/mode7_floor_pixel_sampler_core.sv */
// Stages: request capture, a 32-stage row divider, a 48-stage scale divider,
// then multiply, sum, map read and tile read stages.
// Throughput: one request per cycle; the whole pipeline holds while the
// result register is full and not taken.
// Reset: synchronous, clears valid bits and sets configuration registers to their defaults.
// Map and tile stores are not cleared.
module mode7_floor_pixel_sampler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0], address[13:2], write_data[21:14], screen_col[28:22],
   // screen_row[34:29], unused [39:35]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_on[0], line_skipped[1], outside_map[2], out_col[9:3], out_row[15:10]
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int MapW = m7fs_pkg::MapWidthTiles;
   localparam int MapH = m7fs_pkg::MapHeightTiles;

   // Configuration registers
   logic signed [31:0] hp_ff, hsd_ff, camx_ff, camy_ff;
   logic signed [15:0] hor_ff;
   logic [1:0]         rsel_ff;
   logic signed [17:0] cos_ff, sin_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff   <= '0;
         hsd_ff  <= 32'sd65536;
         hor_ff  <= '0;
         rsel_ff <= '0;
         cos_ff  <= 18'sd65536;
         sin_ff  <= '0;
         camx_ff <= '0;
         camy_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            m7fs_pkg::REG_HEIGHT_PRODUCT: hp_ff   <= csr_data;
            m7fs_pkg::REG_HSCALE_DIV:     hsd_ff  <= csr_data;
            m7fs_pkg::REG_HORIZON:        hor_ff  <= csr_data[15:0];
            m7fs_pkg::REG_RENDER_SELECT:  rsel_ff <= csr_data[1:0];
            m7fs_pkg::REG_COS:            cos_ff  <= csr_data[17:0];
            m7fs_pkg::REG_SIN:            sin_ff  <= csr_data[17:0];
            m7fs_pkg::REG_CAM_X:          camx_ff <= csr_data;
            m7fs_pkg::REG_CAM_Y:          camy_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Global advance: the pipeline moves unless the result register is stuck
   logic rsp_vld_ff;
   logic advance;
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance;

   // Stage 0: capture the request
   logic              s0_vld_ff;
   m7fs_pkg::item_type s0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (advance) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff.op   <= req_tdata[1:0];
         s0_ff.addr <= req_tdata[13:2];
         s0_ff.data <= req_tdata[21:14];
         s0_ff.col  <= req_tdata[28:22];
         s0_ff.row  <= req_tdata[34:29];
      end
   end

   // Row divisor and operand magnitudes for the distance divide
   logic signed [16:0]      rdiv;
   logic [31:0]             hp_mag;
   logic [16:0]             rdiv_mag;
   m7fs_pkg::div1_side_type d1_side_in, d1_side_out;
   logic                    d1_vld;
   logic [31:0]             d1_q;

   always_comb begin
      rdiv     = 17'(hor_ff) + 17'(signed'({11'b0, s0_ff.row}));
      hp_mag   = hp_ff[31] ? 32'(-hp_ff) : 32'(hp_ff);
      rdiv_mag = rdiv[16] ? 17'(-rdiv) : 17'(rdiv);
      d1_side_in.item     = s0_ff;
      d1_side_in.zero_div = (rdiv == '0);
      d1_side_in.neg      = hp_ff[31] ^ rdiv[16];
   end

   m7fs_udiv #(
      .NUM_W  (32),
      .DEN_W  (16),
      .SIDE_W ($bits(m7fs_pkg::div1_side_type))
   ) u_div_dist (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .in_vld   (s0_vld_ff),
      .num      (hp_mag),
      .den      (rdiv_mag[15:0]),
      .side_in  (d1_side_in),
      .out_vld  (d1_vld),
      .quot     (d1_q),
      .side_out (d1_side_out)
   );

   // Stage 2: signed distance and mode rejection
   logic              s2_vld_ff;
   m7fs_pkg::s2_type  s2_ff, s2_in;

   always_comb begin
      s2_in.item = d1_side_out.item;
      if (d1_side_out.neg) begin
         s2_in.line_dist = 32'(-d1_q);
      end else if (d1_q[31]) begin
         s2_in.line_dist = m7fs_pkg::S32_MAX;
      end else begin
         s2_in.line_dist = d1_q;
      end
      s2_in.skip = d1_side_out.zero_div
         || (s2_in.line_dist < 0 && rsel_ff == m7fs_pkg::SEL_FLOOR)
         || (s2_in.line_dist > 0 && rsel_ff == m7fs_pkg::SEL_CEILING);
   end

   // Stage 3: distance times cos and sin
   logic              s3_vld_ff;
   m7fs_pkg::s3_type  s3_ff, s3_in;
   logic signed [50:0] pcos, psin;

   always_comb begin
      pcos            = 51'(s2_ff.line_dist) * 51'(cos_ff);
      psin            = 51'(s2_ff.line_dist) * 51'(sin_ff);
      s3_in.item      = s2_ff.item;
      s3_in.skip      = s2_ff.skip;
      s3_in.line_dist = s2_ff.line_dist;
      s3_in.dcos      = pcos[47:16];
      s3_in.dsin      = psin[47:16];
   end

   // Operands of the scale divide
   logic [31:0]             dist_mag, hsd_mag;
   m7fs_pkg::div2_side_type d2_side_in, d2_side_out;
   logic                    d2_vld;
   logic [47:0]             d2_q;

   always_comb begin
      dist_mag = s3_ff.line_dist[31] ? 32'(-s3_ff.line_dist) : 32'(s3_ff.line_dist);
      hsd_mag  = hsd_ff[31] ? 32'(-hsd_ff) : 32'(hsd_ff);
      d2_side_in.item     = s3_ff.item;
      d2_side_in.skip     = s3_ff.skip;
      d2_side_in.neg      = s3_ff.line_dist[31] ^ hsd_ff[31];
      d2_side_in.den_zero = (hsd_ff == '0);
      d2_side_in.num_neg  = s3_ff.line_dist[31];
      d2_side_in.dcos     = s3_ff.dcos;
      d2_side_in.dsin     = s3_ff.dsin;
   end

   m7fs_udiv #(
      .NUM_W  (48),
      .DEN_W  (32),
      .SIDE_W ($bits(m7fs_pkg::div2_side_type))
   ) u_div_scale (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .in_vld   (s3_vld_ff),
      .num      ({dist_mag, 16'b0}),
      .den      (hsd_mag),
      .side_in  (d2_side_in),
      .out_vld  (d2_vld),
      .quot     (d2_q),
      .side_out (d2_side_out)
   );

   // Stage 4: saturate the line step
   logic              s4_vld_ff;
   m7fs_pkg::s4_type  s4_ff, s4_in;

   always_comb begin
      s4_in.item = d2_side_out.item;
      s4_in.skip = d2_side_out.skip;
      s4_in.dcos = d2_side_out.dcos;
      s4_in.dsin = d2_side_out.dsin;
      if (d2_side_out.den_zero) begin
         s4_in.hs = d2_side_out.num_neg ? m7fs_pkg::S32_MIN : m7fs_pkg::S32_MAX;
      end else if (!d2_side_out.neg) begin
         s4_in.hs = (|d2_q[47:31]) ? m7fs_pkg::S32_MAX : d2_q[31:0];
      end else if ((|d2_q[47:32]) || (d2_q[31] && (|d2_q[30:0]))) begin
         s4_in.hs = m7fs_pkg::S32_MIN;
      end else begin
         s4_in.hs = 32'(-d2_q[31:0]);
      end
   end

   // Stage 5: rotated step and camera base
   logic              s5_vld_ff;
   m7fs_pkg::s5_type  s5_ff, s5_in;
   logic signed [18:0] nsin;
   logic signed [50:0] pldx, pldy;

   always_comb begin
      nsin        = -19'(sin_ff);
      pldx        = 51'(nsin) * 51'(s4_ff.hs);
      pldy        = 51'(cos_ff) * 51'(s4_ff.hs);
      s5_in.item  = s4_ff.item;
      s5_in.skip  = s4_ff.skip;
      s5_in.ldx   = pldx[47:16];
      s5_in.ldy   = pldy[47:16];
      s5_in.basex = 32'(camx_ff) + 32'(s4_ff.dcos);
      s5_in.basey = 32'(camy_ff) + 32'(s4_ff.dsin);
   end

   // Stage 6: add the column offset times step
   logic              s6_vld_ff;
   m7fs_pkg::s6_type  s6_ff, s6_in;
   logic signed [31:0] rel;

   always_comb begin
      rel        = 32'(signed'({1'b0, s5_ff.item.col})) - 32'(m7fs_pkg::ScreenWidth / 2);
      s6_in.item = s5_ff.item;
      s6_in.skip = s5_ff.skip;
      s6_in.px   = s5_ff.basex + 32'(rel * s5_ff.ldx);
      s6_in.py   = s5_ff.basey + 32'(rel * s5_ff.ldy);
   end

   // Map bounds, mirrored cell index and map store access
   logic              s7_vld_ff;
   m7fs_pkg::s7_type  s7_ff, s7_in;
   logic [15:0]       sx, sy;
   logic [7:0]        cx, cy;
   logic [19:0]       mi_full;
   logic              map_we;
   logic [11:0]       map_addr;
   logic [7:0]        map_q;

   always_comb begin
      sx      = s6_ff.px[31:16];
      sy      = s6_ff.py[31:16];
      cx      = sx[10:3];
      cy      = sy[10:3];
      mi_full = 20'(cy) * 20'(MapW) + 20'(MapW - 1) - 20'(cx);
      s7_in.item    = s6_ff.item;
      s7_in.skip    = s6_ff.skip;
      s7_in.outside = !(!sx[15] && !sy[15]
                        && (sx < 16'(MapW * 8)) && (sy < 16'(MapH * 8)));
      s7_in.sx3     = sx[2:0];
      s7_in.sy3     = sy[2:0];
      map_we   = advance && s6_vld_ff && (s6_ff.item.op == m7fs_pkg::OP_MAP_WRITE);
      map_addr = (s6_ff.item.op == m7fs_pkg::OP_MAP_WRITE) ? s6_ff.item.addr : mi_full[11:0];
   end

   m7fs_ram #(
      .WIDTH (8),
      .DEPTH (4096)
   ) u_map_ram (
      .clock (clock),
      .en    (advance),
      .we    (map_we),
      .addr  (map_addr),
      .wdata (s6_ff.item.data),
      .rdata (map_q)
   );

   // Tile store access
   logic              s8_vld_ff;
   m7fs_pkg::s8_type  s8_ff, s8_in;
   logic              tile_we;
   logic [10:0]       tile_addr;
   logic [7:0]        tile_q;

   always_comb begin
      s8_in.item    = s7_ff.item;
      s8_in.skip    = s7_ff.skip;
      s8_in.outside = s7_ff.outside;
      s8_in.sx3     = s7_ff.sx3;
      tile_we   = advance && s7_vld_ff && (s7_ff.item.op == m7fs_pkg::OP_TILE_WRITE);
      tile_addr = (s7_ff.item.op == m7fs_pkg::OP_TILE_WRITE)
                  ? s7_ff.item.addr[10:0] : {map_q, s7_ff.sy3};
   end

   m7fs_ram #(
      .WIDTH (8),
      .DEPTH (2048)
   ) u_tile_ram (
      .clock (clock),
      .en    (advance),
      .we    (tile_we),
      .addr  (tile_addr),
      .wdata (s7_ff.item.data),
      .rdata (tile_q)
   );

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= d1_vld;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= d2_vld;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
      end
   end

   // Result register: only render requests produce a result
   logic [15:0] rsp_data_ff;
   logic        pix_on, pix_skip, pix_out;

   always_comb begin
      pix_skip = s8_ff.skip;
      pix_out  = !s8_ff.skip && s8_ff.outside;
      pix_on   = !s8_ff.skip && !s8_ff.outside && tile_q[s8_ff.sx3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= s8_vld_ff && (s8_ff.item.op == m7fs_pkg::OP_RENDER);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {s8_ff.item.row, s8_ff.item.col, pix_out, pix_skip, pix_on};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
